// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the scheduler RTL. Each use must sit in a
// module that has clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Sizes, codes and item structures shared by the round robin scheduler RTL.
// ----------------------------------------------------------------------------
package rrts_pkg;

    // Number of thread slots and the widths that follow from it.
    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    // Fixed field widths of the item and result channels.
    localparam int OP_W     = 3;
    localparam int TID_W    = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_START   = 3'd1,
        OP_YIELD   = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_FINISH  = 3'd4,
        OP_UNBLOCK = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 3'd0,
        STAT_ALL_DONE     = 3'd1,
        STAT_DEADLOCK     = 3'd2,
        STAT_NO_FREE      = 3'd3,
        STAT_NOT_BLOCKED  = 3'd4,
        STAT_NONE_RUNNING = 3'd5
    } sched_status_t;

    typedef enum logic [1:0] {
        TS_FREE    = 2'd0,
        TS_READY   = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_RUNNING = 2'd3
    } thr_state_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [TID_W-1:0] tid;
    } sched_item_t;

    typedef struct packed {
        logic [TID_W-1:0] running_thread;
        logic             running_valid;
        logic [TID_W-1:0] new_thread;
        sched_status_t    status;
    } sched_result_t;

endpackage

// File: rtl/rrts_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one event item and holds it until the core processes it.
// ----------------------------------------------------------------------------
module rrts_in_reg
    import rrts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [TID_W-1:0]    thread_id,
    input  logic                fire,
    output logic                item_valid,
    output sched_item_t         item
);

    logic        valid_reg;
    logic        valid_next;
    sched_item_t item_reg;
    logic        accept;

    // The register frees up in the same cycle that its item is processed.
    assign in_stall   = valid_reg && !fire;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op  <= operation;
            item_reg.tid <= thread_id;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/rrts_core.sv
// ----------------------------------------------------------------------------
// Scheduler core
// Holds the slot states, the ready FIFO and the running thread, and works
// out one event item per cycle while fire is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrts_core
    import rrts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  sched_item_t   item,
    output sched_result_t result
);

    thr_state_t        thr_state_reg  [MAX_THREADS];
    thr_state_t        thr_state_next [MAX_THREADS];
    logic [SLOT_W-1:0] fifo_mem       [MAX_THREADS];
    logic [SLOT_W-1:0] fifo_head_reg, fifo_head_next;
    logic [SLOT_W-1:0] fifo_tail_reg, fifo_tail_next;
    logic [CNT_W-1:0]  fifo_count_reg, fifo_count_next;
    logic [SLOT_W-1:0] cur_thread_reg, cur_thread_next;
    logic              cur_valid_reg, cur_valid_next;

    op_t               op;
    logic [SLOT_W-1:0] tid_idx;
    logic              tid_in_range;
    logic              any_free;
    logic [SLOT_W-1:0] free_idx;
    logic              any_blocked;
    logic [MAX_THREADS-1:0] ready_vec;
    logic              push_en;
    logic              push_ok;
    logic [SLOT_W-1:0] push_slot;
    logic              pop_en;
    logic [SLOT_W-1:0] pop_slot;
    logic              dispatch;
    logic [SLOT_W-1:0] created;
    sched_status_t     status;

    assign op           = op_t'(item.op);
    assign tid_idx      = SLOT_W'(item.tid);
    assign tid_in_range = (32'(item.tid) < 32'(MAX_THREADS));

    // Lowest free slot, plus a summary of blocked and ready slots.
    always_comb
    begin
        any_free    = 1'b0;
        free_idx    = '0;
        any_blocked = 1'b0;
        for (int i = MAX_THREADS - 1; i >= 0; i--)
        begin
            if (thr_state_reg[i] == TS_FREE)
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (thr_state_reg[i] == TS_BLOCKED)
            begin
                any_blocked = 1'b1;
            end
            ready_vec[i] = (thr_state_reg[i] == TS_READY);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            thr_state_next[i] = thr_state_reg[i];
        end
        cur_thread_next = cur_thread_reg;
        cur_valid_next  = cur_valid_reg;
        push_en         = 1'b0;
        push_slot       = '0;
        dispatch        = 1'b0;
        created         = '0;
        status          = STAT_OK;

        case (op)
            OP_CREATE:
            begin
                if (any_free)
                begin
                    thr_state_next[free_idx] = TS_READY;
                    push_en                  = 1'b1;
                    push_slot                = free_idx;
                    created                  = free_idx;
                end
                else
                begin
                    status = STAT_NO_FREE;
                end
            end
            OP_START, OP_YIELD, OP_BLOCK, OP_FINISH:
            begin
                if (!cur_valid_reg && op != OP_START)
                begin
                    status = STAT_NONE_RUNNING;
                end
                else
                begin
                    if (cur_valid_reg)
                    begin
                        if (op == OP_BLOCK)
                        begin
                            thr_state_next[cur_thread_reg] = TS_BLOCKED;
                        end
                        else if (op == OP_FINISH)
                        begin
                            thr_state_next[cur_thread_reg] = TS_FREE;
                        end
                        else
                        begin
                            thr_state_next[cur_thread_reg] = TS_READY;
                            push_en                        = 1'b1;
                            push_slot                      = cur_thread_reg;
                        end
                    end
                    dispatch = 1'b1;
                end
            end
            OP_UNBLOCK:
            begin
                if (tid_in_range && thr_state_reg[tid_idx] == TS_BLOCKED)
                begin
                    thr_state_next[tid_idx] = TS_READY;
                    push_en                 = 1'b1;
                    push_slot               = tid_idx;
                end
                else
                begin
                    status = STAT_NOT_BLOCKED;
                end
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase

        // A full FIFO cannot occur, since each slot is queued at most once,
        // but the push is still guarded.
        push_ok = push_en && (fifo_count_reg < CNT_W'(MAX_THREADS));

        // Dispatch pops the head; a slot pushed into an empty FIFO in this
        // same item is forwarded straight through.
        pop_en   = 1'b0;
        pop_slot = (fifo_count_reg == '0) ? push_slot : fifo_mem[fifo_head_reg];
        if (dispatch)
        begin
            if (fifo_count_reg != '0 || push_ok)
            begin
                pop_en                   = 1'b1;
                cur_thread_next          = pop_slot;
                cur_valid_next           = 1'b1;
                thr_state_next[pop_slot] = TS_RUNNING;
            end
            else
            begin
                cur_thread_next = '0;
                cur_valid_next  = 1'b0;
                if (any_blocked || (op == OP_BLOCK && cur_valid_reg))
                begin
                    status = STAT_DEADLOCK;
                end
                else
                begin
                    status = STAT_ALL_DONE;
                end
            end
        end

        fifo_tail_next = fifo_tail_reg;
        if (push_ok)
        begin
            fifo_tail_next = (fifo_tail_reg == SLOT_W'(MAX_THREADS - 1)) ?
                             '0 : fifo_tail_reg + 1'b1;
        end
        fifo_head_next = fifo_head_reg;
        if (pop_en)
        begin
            fifo_head_next = (fifo_head_reg == SLOT_W'(MAX_THREADS - 1)) ?
                             '0 : fifo_head_reg + 1'b1;
        end
        fifo_count_next = fifo_count_reg + CNT_W'(push_ok) - CNT_W'(pop_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                thr_state_reg[i] <= TS_FREE;
            end
            fifo_head_reg  <= '0;
            fifo_tail_reg  <= '0;
            fifo_count_reg <= '0;
            cur_thread_reg <= '0;
            cur_valid_reg  <= 1'b0;
        end
        else if (fire)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                thr_state_reg[i] <= thr_state_next[i];
            end
            fifo_head_reg  <= fifo_head_next;
            fifo_tail_reg  <= fifo_tail_next;
            fifo_count_reg <= fifo_count_next;
            cur_thread_reg <= cur_thread_next;
            cur_valid_reg  <= cur_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && push_ok)
        begin
            fifo_mem[fifo_tail_reg] <= push_slot;
        end
    end

    always_comb
    begin
        result.running_thread = cur_valid_next ? TID_W'(cur_thread_next) : '0;
        result.running_valid  = cur_valid_next;
        result.new_thread     = TID_W'(created);
        result.status         = status;
    end

    `ASSERT_IMPL(a_count_bound, 1'b1, fifo_count_reg <= CNT_W'(MAX_THREADS),
        "ready FIFO count exceeds the number of slots")
    `ASSERT_IMPL(a_count_matches_ready, 1'b1,
        $countones(ready_vec) == int'(fifo_count_reg),
        "ready FIFO count differs from the number of ready slots")
    `ASSERT_IMPL(a_running_state, cur_valid_reg,
        thr_state_reg[cur_thread_reg] == TS_RUNNING,
        "running thread is not marked running")

endmodule

// File: rtl/rrts_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrts_out_reg
    import rrts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  sched_result_t        result,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TID_W-1:0]     running_thread,
    output logic                 running_valid,
    output logic [TID_W-1:0]     new_thread,
    output logic [STATUS_W-1:0]  status
);

    logic          valid_reg;
    logic          valid_next;
    sched_result_t result_reg;

    assign valid_next = fire || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = valid_reg;
    assign running_thread = result_reg.running_thread;
    assign running_valid  = result_reg.running_valid;
    assign new_thread     = result_reg.new_thread;
    assign status         = result_reg.status;

    `ASSERT_IMPL(a_no_overwrite, valid_reg && out_stall, !fire,
        "new result would overwrite one still waiting")
    `ASSERT_NEXT(a_fire_shows, fire, valid_reg,
        "processed item did not produce a visible result")

endmodule

// File: rtl/round_robin_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Round robin thread scheduler
// Tracks thread slots and a ready FIFO, and picks the running thread per event.
// ----------------------------------------------------------------------------
// The scheduler takes one event item per clock cycle while neither side
// stalls, and returns exactly one result item for each. An accepted item
// waits in the input register until it is processed, is worked out in a
// single pass against the slot states and the ready FIFO, and its result is
// loaded into the result register as the item is processed, for the output
// side to take from there. The throughput of one item per cycle while
// nothing stalls is set by that single pass, which updates the scheduling
// state in the same cycle so that the next item sees it. The input side
// stalls only while the input register is full and the result register still
// holds a result that the output side is stalling. Create takes the lowest
// free slot and queues it; start, yield, block and finish retire the running
// thread and then pop the head of the ready FIFO; unblock requeues a blocked
// slot. When the FIFO is empty at dispatch, the status reports all done, or
// deadlock if any slot is blocked. There are no configuration registers.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_unit
    import rrts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [TID_W-1:0]     thread_id,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TID_W-1:0]     running_thread,
    output logic                 running_valid,
    output logic [TID_W-1:0]     new_thread,
    output logic [STATUS_W-1:0]  status
);

    logic          item_valid;
    sched_item_t   item;
    sched_result_t result;
    logic          fire;

    // An item is processed when one is waiting and the result register is
    // either empty or being emptied in this cycle.
    assign fire = item_valid && (!out_valid || !out_stall);

    rrts_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .thread_id  (thread_id),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    // All scheduling state lives in the core and advances only on fire.
    rrts_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    rrts_out_reg u_out_reg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .result         (result),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .running_thread (running_thread),
        .running_valid  (running_valid),
        .new_thread     (new_thread),
        .status         (status)
    );

endmodule
